// File: rtl/dmb_pkg.sv
`default_nettype none
package dmb_pkg;

   localparam int unsigned NBTN = 3;
   localparam int unsigned CNT_W = 16;
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CNT_W-1:0] CNT_ONE = 16'd1;

   localparam int unsigned LANE_OFF   = 0;
   localparam int unsigned LANE_CONT  = 1;
   localparam int unsigned LANE_TIMED = 2;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_FORCE = 1'b1;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_CONT  = 2'd1;
   localparam logic [1:0] MODE_TIMER = 2'd2;

   typedef struct packed {
      logic       cmd;
      logic       off_level;
      logic       cont_level;
      logic       timed_level;
      logic [1:0] set_mode;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       tuner_on;
      logic       continuous_on;
      logic [2:0] press_mask;
   } rsp_type;

   // what the merge stage is told about the accepted item
   typedef struct packed {
      logic       tick;
      logic       forced;
      logic [1:0] set_mode;
   } step_type;

endpackage
`default_nettype wire

// File: rtl/dmb_lane.sv
`default_nettype none
module dmb_lane (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      tick,
   input  wire logic                      level,
   input  wire logic [dmb_pkg::CNT_W-1:0] debounce_ticks,
   output logic                           press
);

   logic                         last_ff, last_in;
   logic                         wait_ff, wait_in;
   logic [dmb_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      last_in = last_ff;
      wait_in = wait_ff;
      cnt_in  = cnt_ff;
      press   = 1'b0;
      if (tick) begin
         last_in = level;
         if (wait_ff) begin
            if (cnt_ff <= dmb_pkg::CNT_ONE) begin
               wait_in = 1'b0;
               cnt_in  = '0;
               press   = ~level;
            end else begin
               cnt_in = cnt_ff - dmb_pkg::CNT_ONE;
            end
         end else if (last_ff && !level) begin
            // armed and falling edge: start countdown; zero acts as one
            wait_in = 1'b1;
            cnt_in  = debounce_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b1;
         wait_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         last_ff <= last_in;
         wait_ff <= wait_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/dmb_merge.sv
`default_nettype none
module dmb_merge (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dmb_pkg::step_type        step,
   input  wire logic [dmb_pkg::NBTN-1:0] press,
   output dmb_pkg::rsp_type              result
);

   logic [1:0] mode_ff, mode_in;
   logic       tuner_ff, tuner_in;
   logic       cont_ff, cont_in;

   always_comb begin
      mode_in  = mode_ff;
      tuner_in = tuner_ff;
      cont_in  = cont_ff;
      if (step.forced) begin
         if (step.set_mode == dmb_pkg::MODE_IDLE || step.set_mode == dmb_pkg::MODE_CONT ||
             step.set_mode == dmb_pkg::MODE_TIMER) begin
            mode_in = step.set_mode;
         end
      end else if (step.tick) begin
         // fixed order: off, continuous, timed
         if (press[dmb_pkg::LANE_OFF]) begin
            tuner_in = ~tuner_in;
            if (!tuner_in) begin
               mode_in = dmb_pkg::MODE_IDLE;
               cont_in = 1'b0;
            end
         end
         if (press[dmb_pkg::LANE_CONT]) begin
            cont_in  = ~cont_in;
            tuner_in = 1'b1;
            mode_in  = dmb_pkg::MODE_CONT;
         end
         if (press[dmb_pkg::LANE_TIMED]) begin
            tuner_in = 1'b1;
            mode_in  = dmb_pkg::MODE_TIMER;
            cont_in  = 1'b0;
         end
      end
   end

   always_comb begin
      result.mode          = mode_in;
      result.tuner_on      = tuner_in;
      result.continuous_on = cont_in;
      result.press_mask    = step.tick ? press : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= dmb_pkg::MODE_IDLE;
         tuner_ff <= 1'b0;
         cont_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         tuner_ff <= tuner_in;
         cont_ff  <= cont_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/debounced_mode_buttons.sv
`default_nettype none
// Channel | Ports                              | Carries
// req     | req_valid, req_ready, req_data     | one tick or force item
// rsp     | rsp_valid, rsp_ready, rsp_data     | mode, flags, confirmed presses
// csr     | csr_we, csr_wdata                  | debounce_ticks, written at once
//
// One item per clock unless rsp stalls: three button lanes count down in parallel
// and the merge stage applies their presses in the same cycle; the result enters
// the output register in the cycle after acceptance. Input is taken whenever that
// register is empty or being drained, so a stalled rsp side stalls req only
// while its result sits unclaimed. Synchronous reset; debounce_ticks resets to 50.
module debounced_mode_buttons (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire dmb_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output dmb_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [dmb_pkg::CNT_W-1:0] csr_wdata
);

   logic [dmb_pkg::CNT_W-1:0] debounce_ff;
   logic                      rsp_valid_ff;
   dmb_pkg::rsp_type          rsp_data_ff;
   logic                      accept;
   dmb_pkg::step_type         step;
   logic [dmb_pkg::NBTN-1:0]  levels;
   logic [dmb_pkg::NBTN-1:0]  press;
   dmb_pkg::rsp_type          result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign step.tick     = accept && (req_data.cmd == dmb_pkg::CMD_TICK);
   assign step.forced   = accept && (req_data.cmd == dmb_pkg::CMD_FORCE);
   assign step.set_mode = req_data.set_mode;

   assign levels[dmb_pkg::LANE_OFF]   = req_data.off_level;
   assign levels[dmb_pkg::LANE_CONT]  = req_data.cont_level;
   assign levels[dmb_pkg::LANE_TIMED] = req_data.timed_level;

   for (genvar g = 0; g < dmb_pkg::NBTN; g++) begin : g_lane
      dmb_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .tick           (step.tick),
         .level          (levels[g]),
         .debounce_ticks (debounce_ff),
         .press          (press[g])
      );
   end

   dmb_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .press  (press),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= dmb_pkg::DEBOUNCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            debounce_ff <= csr_wdata;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   a_force_no_press: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.cmd == dmb_pkg::CMD_FORCE |=> rsp_valid && rsp_data.press_mask == '0)
      else $error("force item reported a press");

   a_cont_needs_tuner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tuner_on |-> !rsp_data.continuous_on)
      else $error("continuous flag set with tuner off");

   a_timed_wins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.press_mask[dmb_pkg::LANE_TIMED] |->
         rsp_data.tuner_on && rsp_data.mode == dmb_pkg::MODE_TIMER &&
         !rsp_data.continuous_on)
      else $error("timed press not applied last");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.mode == dmb_pkg::MODE_IDLE || rsp_data.mode == dmb_pkg::MODE_CONT ||
         rsp_data.mode == dmb_pkg::MODE_TIMER)
      else $error("illegal mode reported");

endmodule
`default_nettype wire
